[hdl/bgd_pkg.sv]
// shared types and constants for the 3-d block grid decomposer
// no dependencies
`timescale 1ns / 1ps

package bgd_pkg;

	localparam int REG_BITS   = 16;
	localparam int COORD_BITS = 16;
	localparam int START_BITS = COORD_BITS + 1;
	localparam int SIZE_BITS  = COORD_BITS;
	localparam int VOL_BITS   = 3 * REG_BITS;
	localparam int ROOT_BITS  = 18;
	localparam int MUL_A_BITS = 2 * ROOT_BITS;
	localparam int MUL_B_BITS = ROOT_BITS;
	localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MISMATCH  = 2'd1,
		ST_ZERO_EDGE = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_EXTENT_X  = 3'd0,
		REG_EXTENT_Y  = 3'd1,
		REG_EXTENT_Z  = 3'd2,
		REG_PROC_CNT  = 3'd3,
		REG_LAYOUT_X  = 3'd4,
		REG_LAYOUT_Y  = 3'd5,
		REG_LAYOUT_Z  = 3'd6
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_VOL1,
		S_VOL2,
		S_VOL3,
		S_VDIV,
		S_ROOT1,
		S_ROOT2,
		S_ROOT3,
		S_MCHK,
		S_PDIV,
		S_PWAIT,
		S_PROD1,
		S_PROD2,
		S_PROD3,
		S_PLDIV,
		S_PLWAIT,
		S_PLMUL,
		S_PLADD,
		S_FINISH
	} state_t;

endpackage

[hdl/bgd_query_if.sv]
// query and result channel interfaces of the grid decomposer
// depends on bgd_pkg
`timescale 1ns / 1ps

interface bgd_query_if;
	logic                        valid;
	logic                        ready;
	logic [bgd_pkg::REG_BITS-1:0] proc_p;
	logic [bgd_pkg::REG_BITS-1:0] proc_q;
	logic [bgd_pkg::REG_BITS-1:0] proc_r;
	logic [bgd_pkg::REG_BITS-1:0] origin_x;
	logic [bgd_pkg::REG_BITS-1:0] origin_y;
	logic [bgd_pkg::REG_BITS-1:0] origin_z;

	modport source (output valid, proc_p, proc_q, proc_r, origin_x, origin_y, origin_z,
		input ready);
	modport sink (input valid, proc_p, proc_q, proc_r, origin_x, origin_y, origin_z,
		output ready);
endinterface

interface bgd_result_if;
	logic                          valid;
	logic                          ready;
	logic [bgd_pkg::START_BITS-1:0] start_x;
	logic [bgd_pkg::START_BITS-1:0] start_y;
	logic [bgd_pkg::START_BITS-1:0] start_z;
	logic [bgd_pkg::SIZE_BITS-1:0]  size_x;
	logic [bgd_pkg::SIZE_BITS-1:0]  size_y;
	logic [bgd_pkg::SIZE_BITS-1:0]  size_z;
	logic [bgd_pkg::REG_BITS-1:0]   used_layout_x;
	logic [bgd_pkg::REG_BITS-1:0]   used_layout_y;
	logic [bgd_pkg::REG_BITS-1:0]   used_layout_z;
	logic [1:0]                     status;

	modport source (output valid, start_x, start_y, start_z, size_x, size_y, size_z,
		used_layout_x, used_layout_y, used_layout_z, status, input ready);
	modport sink (input valid, start_x, start_y, start_z, size_x, size_y, size_z,
		used_layout_x, used_layout_y, used_layout_z, status, output ready);
endinterface

[hdl/bgd_div.sv]
// iterative restoring divider, one quotient bit per cycle
// depends on bgd_pkg
`timescale 1ns / 1ps

module bgd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bgd_pkg::VOL_BITS-1:0]  dividend,
	input  logic [bgd_pkg::ROOT_BITS-1:0] divisor,
	output logic                          busy,
	output logic [bgd_pkg::VOL_BITS-1:0]  quot,
	output logic [bgd_pkg::ROOT_BITS-1:0] rem
);
	import bgd_pkg::*;

	localparam int CNT_BITS = $clog2(VOL_BITS);

	logic                 busy_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [VOL_BITS-1:0]  dvd_q;
	logic [ROOT_BITS-1:0] dvs_q;
	logic [ROOT_BITS-1:0] rem_q;
	logic [ROOT_BITS:0]   trial;
	logic [ROOT_BITS:0]   diff;
	logic                 ge;

	assign trial = {rem_q, dvd_q[VOL_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(VOL_BITS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[ROOT_BITS-1:0] : trial[ROOT_BITS-1:0];
			dvd_q <= {dvd_q[VOL_BITS-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = dvd_q;
	assign rem  = rem_q;
endmodule

[hdl/bgd_mul.sv]
// shared registered multiplier, product registered in the cycle after the operands
// depends on bgd_pkg
`timescale 1ns / 1ps

module bgd_mul (
	input  logic                           clk,
	input  logic [bgd_pkg::MUL_A_BITS-1:0] a,
	input  logic [bgd_pkg::MUL_B_BITS-1:0] b,
	output logic [bgd_pkg::MUL_P_BITS-1:0] p
);
	import bgd_pkg::*;

	logic [MUL_P_BITS-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_BITS'(a) * MUL_P_BITS'(b);
	end

	assign p = p_q;
endmodule

[hdl/block_grid_decomposer_3d.sv]
// 3-d block grid decomposer: top level with sequencer and register file
// depends on bgd_pkg, bgd_query_if, bgd_result_if, bgd_div, bgd_mul
//
// usage: load extents, process count and layout through the write port
// (cfg_we, cfg_index, cfg_data) while idle. each query beat names a process
// coordinate and grid origin; one result beat follows with start, size,
// layout used and status.
// one query is worked at a time; query.ready is high only while idle.
// all multiplies and divides go through one registered multiplier and one
// restoring divider.
// with a given layout, placement takes three divides.
// with a derived layout: volume and cube root first, then three divides per
// trial block edge, then placement.
// a finished result sits in the output register; the next query may be
// taken and worked while it waits, and the sequencer holds its last step
// until result.ready frees the register.
// reset: extents and process count go to 1, layout to 0, no beat pending.
`timescale 1ns / 1ps

module block_grid_decomposer_3d (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bgd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bgd_pkg::REG_BITS-1:0]      cfg_data,
	bgd_query_if.sink                         query,
	bgd_result_if.source                      result
);
	import bgd_pkg::*;

	logic [REG_BITS-1:0] ext_x_q, ext_y_q, ext_z_q, pc_q;
	logic [REG_BITS-1:0] lay_x_q, lay_y_q, lay_z_q;

	state_t state_q, state_d;

	logic [REG_BITS-1:0]   p_q, q_q, r_q, ox_q, oy_q, oz_q;
	logic [VOL_BITS-1:0]   vol_q;
	logic [ROOT_BITS-1:0]  root_q, m_q;
	logic [4:0]            bit_q;
	logic [1:0]            axis_q;
	logic                  derive_q;
	logic [REG_BITS-1:0]   lp_q, lq_q, lr_q;
	logic [REG_BITS-1:0]   base_q, extra_q;
	logic [START_BITS-1:0] sx_q, sy_q, sz_q;
	logic [SIZE_BITS-1:0]  zx_q, zy_q, zz_q;
	status_t               status_q;

	logic                  out_valid_q;
	logic [START_BITS-1:0] o_sx_q, o_sy_q, o_sz_q;
	logic [SIZE_BITS-1:0]  o_zx_q, o_zy_q, o_zz_q;
	logic [REG_BITS-1:0]   o_lx_q, o_ly_q, o_lz_q;
	logic [1:0]            o_st_q;

	logic [MUL_A_BITS-1:0] mul_a;
	logic [MUL_B_BITS-1:0] mul_b;
	logic [MUL_P_BITS-1:0] mul_p;
	logic                  div_start;
	logic [VOL_BITS-1:0]   div_dvd;
	logic [ROOT_BITS-1:0]  div_dvs;
	logic                  div_busy;
	logic [VOL_BITS-1:0]   div_quot;
	logic [ROOT_BITS-1:0]  div_rem;

	logic                  accept;
	logic                  slot_free;
	logic [ROOT_BITS-1:0]  cand;
	logic [REG_BITS-1:0]   n_sel, parts_sel, k_sel;
	logic [REG_BITS:0]     cnt_sum;
	logic [VOL_BITS-1:0]   prod;
	logic [REG_BITS-1:0]   k_min;
	logic                  k_lt;
	logic [MUL_P_BITS-1:0] start_sum;
	logic [SIZE_BITS:0]    size_sum;

	function automatic logic [REG_BITS-1:0] n_sel_org(input logic [1:0] ax);
		case (ax)
			2'd0:    n_sel_org = ox_q;
			2'd1:    n_sel_org = oy_q;
			default: n_sel_org = oz_q;
		endcase
	endfunction

	bgd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	bgd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_x_q <= REG_BITS'(1);
			ext_y_q <= REG_BITS'(1);
			ext_z_q <= REG_BITS'(1);
			pc_q    <= REG_BITS'(1);
			lay_x_q <= '0;
			lay_y_q <= '0;
			lay_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXTENT_X: ext_x_q <= cfg_data;
				REG_EXTENT_Y: ext_y_q <= cfg_data;
				REG_EXTENT_Z: ext_z_q <= cfg_data;
				REG_PROC_CNT: pc_q    <= cfg_data;
				REG_LAYOUT_X: lay_x_q <= cfg_data;
				REG_LAYOUT_Y: lay_y_q <= cfg_data;
				REG_LAYOUT_Z: lay_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept    = query.valid && query.ready;
	assign slot_free = !out_valid_q || result.ready;
	assign cand      = root_q | (ROOT_BITS'(1) << bit_q);
	assign prod      = mul_p[VOL_BITS-1:0];

	always_comb begin
		case (axis_q)
			2'd0: begin
				n_sel = ext_x_q; parts_sel = lp_q; k_sel = p_q;
			end
			2'd1: begin
				n_sel = ext_y_q; parts_sel = lq_q; k_sel = q_q;
			end
			default: begin
				n_sel = ext_z_q; parts_sel = lr_q; k_sel = r_q;
			end
		endcase
	end

	assign cnt_sum   = {1'b0, div_quot[REG_BITS-1:0]} +
		(REG_BITS + 1)'(div_rem > div_quot[ROOT_BITS-1:0]);
	assign k_lt      = k_sel < extra_q;
	assign k_min     = k_lt ? k_sel : extra_q;
	assign start_sum = mul_p + MUL_P_BITS'(k_min) + MUL_P_BITS'(n_sel_org(axis_q));
	assign size_sum  = {1'b0, base_q} + (SIZE_BITS + 1)'(k_lt);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		query.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				query.ready = 1'b1;
				if (query.valid) begin
					if (pc_q == '0)
						state_d = S_FINISH;
					else if (lay_x_q == '0 || lay_y_q == '0 || lay_z_q == '0)
						state_d = S_VOL1;
					else
						state_d = S_PROD1;
				end
			end
			S_VOL1: begin
				mul_a   = MUL_A_BITS'(ext_x_q);
				mul_b   = MUL_B_BITS'(ext_y_q);
				state_d = S_VOL2;
			end
			S_VOL2: begin
				mul_a   = mul_p[MUL_A_BITS-1:0];
				mul_b   = MUL_B_BITS'(ext_z_q);
				state_d = S_VOL3;
			end
			S_VOL3: begin
				div_start = 1'b1;
				div_dvd   = prod;
				div_dvs   = ROOT_BITS'(pc_q);
				state_d   = S_VDIV;
			end
			S_VDIV: begin
				if (!div_busy)
					state_d = S_ROOT1;
			end
			S_ROOT1: begin
				mul_a   = MUL_A_BITS'(cand);
				mul_b   = cand;
				state_d = S_ROOT2;
			end
			S_ROOT2: begin
				mul_a   = mul_p[MUL_A_BITS-1:0];
				mul_b   = cand;
				state_d = S_ROOT3;
			end
			S_ROOT3: begin
				state_d = (bit_q == '0) ? S_MCHK : S_ROOT1;
			end
			S_MCHK: begin
				state_d = (root_q == '0) ? S_FINISH : S_PDIV;
			end
			S_PDIV: begin
				div_start = 1'b1;
				div_dvd   = VOL_BITS'(n_sel);
				div_dvs   = m_q;
				state_d   = S_PWAIT;
			end
			S_PWAIT: begin
				if (!div_busy)
					state_d = (axis_q == 2'd2) ? S_PROD1 : S_PDIV;
			end
			S_PROD1: begin
				mul_a   = MUL_A_BITS'(lp_q);
				mul_b   = MUL_B_BITS'(lq_q);
				state_d = S_PROD2;
			end
			S_PROD2: begin
				mul_a   = mul_p[MUL_A_BITS-1:0];
				mul_b   = MUL_B_BITS'(lr_q);
				state_d = S_PROD3;
			end
			S_PROD3: begin
				if (derive_q && prod > VOL_BITS'(pc_q))
					state_d = S_PDIV;
				else if (prod != VOL_BITS'(pc_q))
					state_d = S_FINISH;
				else if (p_q >= lp_q || q_q >= lq_q || r_q >= lr_q)
					state_d = S_FINISH;
				else
					state_d = S_PLDIV;
			end
			S_PLDIV: begin
				div_start = 1'b1;
				div_dvd   = VOL_BITS'(n_sel);
				div_dvs   = ROOT_BITS'(parts_sel);
				state_d   = S_PLWAIT;
			end
			S_PLWAIT: begin
				if (!div_busy)
					state_d = S_PLMUL;
			end
			S_PLMUL: begin
				mul_a   = MUL_A_BITS'(k_sel);
				mul_b   = MUL_B_BITS'(base_q);
				state_d = S_PLADD;
			end
			S_PLADD: begin
				state_d = (axis_q == 2'd2) ? S_FINISH : S_PLDIV;
			end
			S_FINISH: begin
				if (slot_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					p_q      <= query.proc_p;
					q_q      <= query.proc_q;
					r_q      <= query.proc_r;
					ox_q     <= query.origin_x;
					oy_q     <= query.origin_y;
					oz_q     <= query.origin_z;
					derive_q <= lay_x_q == '0 || lay_y_q == '0 || lay_z_q == '0;
					sx_q <= '0; sy_q <= '0; sz_q <= '0;
					zx_q <= '0; zy_q <= '0; zz_q <= '0;
					if (pc_q == '0) begin
						status_q <= ST_MISMATCH;
						lp_q <= '0; lq_q <= '0; lr_q <= '0;
					end else if (lay_x_q == '0 || lay_y_q == '0 || lay_z_q == '0) begin
						status_q <= ST_OK;
						lp_q <= '0; lq_q <= '0; lr_q <= '0;
					end else begin
						status_q <= ST_OK;
						lp_q <= lay_x_q; lq_q <= lay_y_q; lr_q <= lay_z_q;
					end
				end
			end
			S_VDIV: begin
				vol_q  <= div_quot;
				root_q <= '0;
				bit_q  <= 5'(ROOT_BITS - 1);
			end
			S_ROOT3: begin
				if (prod <= vol_q && mul_p[MUL_P_BITS-1:VOL_BITS] == '0)
					root_q <= cand;
				bit_q <= bit_q - 1'b1;
			end
			S_MCHK: begin
				m_q    <= root_q;
				axis_q <= 2'd0;
				if (root_q == '0)
					status_q <= ST_ZERO_EDGE;
			end
			S_PWAIT: begin
				if (!div_busy) begin
					case (axis_q)
						2'd0:    lp_q <= cnt_sum[REG_BITS-1:0];
						2'd1:    lq_q <= cnt_sum[REG_BITS-1:0];
						default: lr_q <= cnt_sum[REG_BITS-1:0];
					endcase
					axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
				end
			end
			S_PROD3: begin
				axis_q <= 2'd0;
				if (derive_q && prod > VOL_BITS'(pc_q))
					m_q <= m_q + 1'b1;
				else if (prod != VOL_BITS'(pc_q))
					status_q <= ST_MISMATCH;
				else if (p_q >= lp_q || q_q >= lq_q || r_q >= lr_q)
					status_q <= ST_RANGE;
			end
			S_PLWAIT: begin
				base_q  <= div_quot[REG_BITS-1:0];
				extra_q <= div_rem[REG_BITS-1:0];
			end
			S_PLADD: begin
				case (axis_q)
					2'd0: begin
						sx_q <= start_sum[START_BITS-1:0]; zx_q <= size_sum[SIZE_BITS-1:0];
					end
					2'd1: begin
						sy_q <= start_sum[START_BITS-1:0]; zy_q <= size_sum[SIZE_BITS-1:0];
					end
					default: begin
						sz_q <= start_sum[START_BITS-1:0]; zz_q <= size_sum[SIZE_BITS-1:0];
					end
				endcase
				axis_q <= axis_q + 1'b1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_FINISH && slot_free)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && slot_free) begin
			o_sx_q <= sx_q; o_sy_q <= sy_q; o_sz_q <= sz_q;
			o_zx_q <= zx_q; o_zy_q <= zy_q; o_zz_q <= zz_q;
			o_lx_q <= lp_q; o_ly_q <= lq_q; o_lz_q <= lr_q;
			o_st_q <= status_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.start_x       = o_sx_q;
	assign result.start_y       = o_sy_q;
	assign result.start_z       = o_sz_q;
	assign result.size_x        = o_zx_q;
	assign result.size_y        = o_zy_q;
	assign result.size_z        = o_zz_q;
	assign result.used_layout_x = o_lx_q;
	assign result.used_layout_y = o_ly_q;
	assign result.used_layout_z = o_lz_q;
	assign result.status        = o_st_q;
endmodule

[bench/block_grid_decomposer_3d_check.sv]
// checker for the 3-d block grid decomposer: snoops config writes, predicts each query's
// answer and compares it with the result beats in order
// depends on bgd_pkg, bgd_query_if, bgd_result_if
`timescale 1ns / 1ps

module block_grid_decomposer_3d_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bgd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bgd_pkg::REG_BITS-1:0]      cfg_data,
	bgd_query_if                              query,
	bgd_result_if                             result,
	output int                                fail_count,
	output int                                pending,
	output logic [bgd_pkg::REG_BITS-1:0]      lay_x,
	output logic [bgd_pkg::REG_BITS-1:0]      lay_y,
	output logic [bgd_pkg::REG_BITS-1:0]      lay_z
);
	import bgd_pkg::*;

	typedef struct {
		longint unsigned sx, sy, sz;
		longint unsigned nx, ny, nz;
		longint unsigned lx, ly, lz;
		status_t         st;
	} answer_t;

	logic [REG_BITS-1:0] ext_x, ext_y, ext_z, proc_cnt, reg_lx, reg_ly, reg_lz;
	answer_t answers[$];

	function automatic longint unsigned icbrt(input longint unsigned v);
		longint unsigned r, c;
		r = 0;
		for (int b = 17; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c * c <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic longint unsigned edge_parts(input longint unsigned n,
		input longint unsigned m);
		longint unsigned k;
		k = n / m;
		return k + (((n % m) > k) ? 1 : 0);
	endfunction

	// layout in effect and the status it implies before the coordinate check
	function automatic status_t plan_layout(output longint unsigned lp, lq, lr);
		longint unsigned m, vol;
		lp = reg_lx;
		lq = reg_ly;
		lr = reg_lz;
		if (proc_cnt == 0) begin
			lp = 0;
			lq = 0;
			lr = 0;
			return ST_MISMATCH;
		end
		if (lp == 0 || lq == 0 || lr == 0) begin
			vol = longint'(ext_x) * ext_y * ext_z;
			m = icbrt(vol / proc_cnt);
			if (m == 0) begin
				lp = 0;
				lq = 0;
				lr = 0;
				return ST_ZERO_EDGE;
			end
			forever begin
				lp = edge_parts(ext_x, m);
				lq = edge_parts(ext_y, m);
				lr = edge_parts(ext_z, m);
				if (lp * lq * lr <= proc_cnt)
					break;
				m++;
			end
		end
		return (lp * lq * lr != proc_cnt) ? ST_MISMATCH : ST_OK;
	endfunction

	function automatic void place_part(input longint unsigned k, n, parts, org,
		output longint unsigned first, cnt);
		longint unsigned base, extra;
		base = n / parts;
		extra = n % parts;
		first = (k * base + ((k < extra) ? k : extra) + org) & ((64'd1 << START_BITS) - 1);
		cnt = (base + ((k < extra) ? 1 : 0)) & ((64'd1 << SIZE_BITS) - 1);
	endfunction

	function automatic answer_t decompose(input longint unsigned p, q, r, ox, oy, oz);
		answer_t a;
		longint unsigned lp, lq, lr;
		a = '{default: 0, st: ST_OK};
		a.st = plan_layout(lp, lq, lr);
		if (a.st == ST_ZERO_EDGE)
			return a;
		if (a.st == ST_OK && (p >= lp || q >= lq || r >= lr))
			a.st = ST_RANGE;
		a.lx = lp & 16'hffff;
		a.ly = lq & 16'hffff;
		a.lz = lr & 16'hffff;
		if (a.st == ST_OK) begin
			place_part(p, ext_x, lp, ox, a.sx, a.nx);
			place_part(q, ext_y, lq, oy, a.sy, a.ny);
			place_part(r, ext_z, lr, oz, a.sz, a.nz);
		end
		return a;
	endfunction

	always_comb begin
		longint unsigned lp, lq, lr;
		void'(plan_layout(lp, lq, lr));
		lay_x = lp[15:0];
		lay_y = lq[15:0];
		lay_z = lr[15:0];
	end

	task automatic check_field(input string name, input longint unsigned want, got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			ext_x <= 1;
			ext_y <= 1;
			ext_z <= 1;
			proc_cnt <= 1;
			reg_lx <= 0;
			reg_ly <= 0;
			reg_lz <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_EXTENT_X: ext_x <= cfg_data;
					REG_EXTENT_Y: ext_y <= cfg_data;
					REG_EXTENT_Z: ext_z <= cfg_data;
					REG_PROC_CNT: proc_cnt <= cfg_data;
					REG_LAYOUT_X: reg_lx <= cfg_data;
					REG_LAYOUT_Y: reg_ly <= cfg_data;
					REG_LAYOUT_Z: reg_lz <= cfg_data;
					default: ;
				endcase
			end
			if (query.valid && query.ready)
				answers.push_back(decompose(query.proc_p, query.proc_q, query.proc_r,
					query.origin_x, query.origin_y, query.origin_z));
			if (result.valid && result.ready) begin
				if (answers.size() == 0) begin
					$display("%0t: result beat with no query outstanding", $time);
					fail_count++;
				end else begin
					want = answers.pop_front();
					check_field("start_x", want.sx, result.start_x);
					check_field("start_y", want.sy, result.start_y);
					check_field("start_z", want.sz, result.start_z);
					check_field("size_x", want.nx, result.size_x);
					check_field("size_y", want.ny, result.size_y);
					check_field("size_z", want.nz, result.size_z);
					check_field("used_layout_x", want.lx, result.used_layout_x);
					check_field("used_layout_y", want.ly, result.used_layout_y);
					check_field("used_layout_z", want.lz, result.used_layout_z);
					check_field("status", want.st, result.status);
				end
			end
		end
		pending = answers.size();
	end
endmodule

[bench/block_grid_decomposer_3d_test.sv]
// top of the grid decomposer testbench: clock, reset, config phases, query stimulus,
// result back-pressure and the verdict
// depends on bgd_pkg, the channel interfaces, the block and block_grid_decomposer_3d_check
`timescale 1ns / 1ps

module block_grid_decomposer_3d_test;
	import bgd_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 12_000_000;
	localparam int DRAIN_CYCLES = 400;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_BITS-1:0] cfg_index = REG_EXTENT_X;
	logic [REG_BITS-1:0] cfg_data = 0;
	int fail_count, pending, cycles, accepted, rx_stall;
	bit pressure_done, quiet;
	logic [REG_BITS-1:0] lay_x, lay_y, lay_z;

	bgd_query_if query ();
	bgd_result_if result ();

	block_grid_decomposer_3d i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .query(query), .result(result)
	);

	block_grid_decomposer_3d_check i_check (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .query(query), .result(result), .fail_count(fail_count),
		.pending(pending), .lay_x(lay_x), .lay_y(lay_y), .lay_z(lay_z)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold once enough queries went in
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 0;
			rx_stall <= 0;
			accepted <= 0;
			pressure_done <= 0;
		end else begin
			if (query.valid && query.ready)
				accepted <= accepted + 1;
			if (!pressure_done && accepted == 300) begin
				pressure_done <= 1;
				rx_stall <= 3000;
				result.ready <= 0;
			end else if (rx_stall > 0) begin
				rx_stall <= rx_stall - 1;
				result.ready <= 0;
			end else begin
				result.ready <= 1;
				rx_stall <= idle_gap();
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		query.valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_setup(input int ex, ey, ez, pc, lx, ly, lz);
		drain();
		write_reg(REG_EXTENT_X, REG_BITS'(ex));
		write_reg(REG_EXTENT_Y, REG_BITS'(ey));
		write_reg(REG_EXTENT_Z, REG_BITS'(ez));
		write_reg(REG_PROC_CNT, REG_BITS'(pc));
		write_reg(REG_LAYOUT_X, REG_BITS'(lx));
		write_reg(REG_LAYOUT_Y, REG_BITS'(ly));
		write_reg(REG_LAYOUT_Z, REG_BITS'(lz));
		write_reg(REG_UNUSED, REG_BITS'($urandom));
	endtask

	task automatic ask(input logic [REG_BITS-1:0] p, q, r, ox, oy, oz);
		int gap;
		query.valid <= 1;
		query.proc_p <= p;
		query.proc_q <= q;
		query.proc_r <= r;
		query.origin_x <= ox;
		query.origin_y <= oy;
		query.origin_z <= oz;
		do @(posedge clk); while (!query.ready);
		gap = idle_gap();
		if (gap > 0) begin
			query.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [REG_BITS-1:0] pick_coord(input logic [REG_BITS-1:0] lay);
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return (lay == 0) ? '0 : REG_BITS'($urandom_range(0, lay - 1));
		if (r < 88)
			return lay;
		return REG_BITS'($urandom);
	endfunction

	task automatic random_queries(input int n);
		repeat (n) begin
			quiet = ($urandom_range(0, 9) == 0) ? ~quiet : quiet;
			ask(pick_coord(lay_x), pick_coord(lay_y), pick_coord(lay_z),
				REG_BITS'($urandom), REG_BITS'($urandom), REG_BITS'($urandom));
		end
		quiet = 0;
	endtask

	initial begin
		int ex, ey, ez, pc;
		query.valid = 0;
		query.proc_p = 0;
		query.proc_q = 0;
		query.proc_r = 0;
		query.origin_x = 0;
		query.origin_y = 0;
		query.origin_z = 0;
		quiet = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset layout: derived single process
		ask(0, 0, 0, 0, 0, 0);
		ask(0, 0, 0, 16'hffff, 16'hffff, 16'hffff);
		ask(16'hffff, 0, 0, 0, 0, 0);
		ask(0, 16'hffff, 16'hffff, 1, 2, 3);
		// no processes at all
		load_setup(8, 8, 8, 0, 2, 2, 2);
		ask(0, 0, 0, 5, 5, 5);
		// more processes than cells
		load_setup(2, 2, 2, 9, 0, 0, 0);
		ask(0, 0, 0, 5, 5, 5);
		// zero extent, derived and given
		load_setup(0, 4, 4, 2, 0, 0, 0);
		ask(0, 0, 0, 0, 0, 0);
		load_setup(0, 4, 4, 1, 1, 1, 1);
		ask(0, 0, 0, 7, 7, 7);
		// widest grid with origins at the top
		load_setup(65535, 65535, 65535, 4096, 16, 16, 16);
		ask(15, 15, 15, 16'hffff, 16'hffff, 16'hffff);
		ask(0, 7, 15, 16'hffff, 0, 16'haaaa);
		ask(16, 0, 0, 0, 0, 0);
		load_setup(65535, 65535, 65535, 8, 0, 0, 0);
		ask(1, 1, 1, 16'hffff, 16'hffff, 16'hffff);
		ask(0, 1, 2, 0, 0, 0);
		// maximal layout on one axis, product overflow on another
		load_setup(65535, 1, 1, 65535, 65535, 1, 1);
		ask(65534, 0, 0, 16'hffff, 0, 0);
		load_setup(65535, 65535, 65535, 65535, 65535, 65535, 65535);
		ask(0, 0, 0, 0, 0, 0);
		// mismatch with a given layout, derived mismatch, one zero layout axis
		load_setup(100, 37, 1000, 100, 3, 5, 7);
		ask(1, 1, 1, 3, 3, 3);
		load_setup(100, 100, 100, 7, 0, 0, 0);
		ask(0, 0, 0, 1, 1, 1);
		load_setup(60, 40, 20, 24, 0, 5, 3);
		ask(1, 1, 0, 9, 9, 9);

		load_setup(100, 37, 1000, 105, 3, 5, 7);
		random_queries(80);
		load_setup(60, 40, 20, 24, 0, 0, 0);
		random_queries(80);
		load_setup(65535, 65535, 65535, 8, 0, 0, 0);
		random_queries(60);
		load_setup(65535, 1, 1, 65535, 65535, 1, 1);
		random_queries(60);
		repeat (14) begin
			if ($urandom_range(0, 1)) begin
				ex = $urandom_range(1, 24);
				ey = $urandom_range(1, 24);
				ez = $urandom_range(1, 24);
				pc = $urandom_range(1, 32);
				load_setup(ex, ey, ez, pc, 0, 0, 0);
			end else begin
				ex = $urandom_range(1, 8);
				ey = $urandom_range(1, 8);
				ez = $urandom_range(1, 8);
				pc = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 512) : ex * ey * ez;
				load_setup($urandom, $urandom, $urandom, pc, ex, ey, ez);
			end
			random_queries(65);
		end

		drain();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
